>>> hdl/tlba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_pkg: shared types and constants for the aging tlb
// sizes of an entry, the entry record that moves along the ring of cells and
// the control record from the sequencer to the scan unit
// ----------------------------------------------------------------------------
package tlba_pkg;

   localparam int ENTRIES    = 16;
   localparam int PAGE_BITS  = 16;
   localparam int FRAME_BITS = 8;
   localparam int AGE_BITS   = 32;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [AGE_BITS-1:0]   age_type;

   // one tlb entry as held by a cell
   typedef struct packed {
      logic      valid;
      page_type  tag;
      frame_type frame;
      logic      readonly;
      age_type   age;
   } entry_type;

   // sequencer to scan unit
   typedef struct packed {
      logic     active;
      logic     first;
      logic     func;
      page_type vpage;
      logic     write_access;
      idx_type  step;
   } scan_ctrl_type;

endpackage

>>> hdl/tlb_aging_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_aging_lru: fully associative tlb with aging victim choice
// entries sit in a ring of cells that turns once per item past a scan unit;
// a lookup matches and ages entries on the way, an insert finds the lowest
// age and then writes the victim cell directly
// ----------------------------------------------------------------------------
//
//   channel   ports                                 handshake
//   request   req_func req_vpage req_write_access   start high, busy low
//             req_frame_in req_readonly_in
//   response  rsp_hit rsp_frame_out                 rsp_valid, one cycle,
//             rsp_readonly_write                    never held off
//
// sequence: a lookup turns the ring past the single scan unit, one entry per
// ring step, then responds; an insert adds the victim write before the response.
// a new item may be started in the response cycle.
// reset: all entries invalid with zero age, sequencer idle.
// the response side cannot stall, so nothing waits on the receiver.
// ----------------------------------------------------------------------------
module tlb_aging_lru (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  tlba_pkg::page_type         req_vpage,
   input  logic                       req_write_access,
   input  tlba_pkg::frame_type        req_frame_in,
   input  logic                       req_readonly_in,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output tlba_pkg::frame_type        rsp_frame_out,
   output logic                       rsp_readonly_write
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]              state_ff, state_in;
   tlba_pkg::idx_type       step_ff, step_in;
   logic                    func_ff;
   tlba_pkg::page_type      vpage_ff;
   logic                    wr_ff;
   tlba_pkg::frame_type     frame_ff;
   logic                    ro_ff;
   logic                    accept;
   logic                    last_step;
   logic                    shift_en;
   tlba_pkg::scan_ctrl_type scan_ctrl;
   tlba_pkg::entry_type     cell_q [tlba_pkg::ENTRIES];
   tlba_pkg::entry_type     tail;
   tlba_pkg::entry_type     new_entry;
   logic [tlba_pkg::ENTRIES-1:0] load_en;
   tlba_pkg::idx_type       victim;
   tlba_pkg::age_type       victim_age;

   assign busy      = (state_ff == ST_SCAN) || (state_ff == ST_WRITE);
   assign accept    = start && !busy;
   assign last_step = (step_ff == tlba_pkg::idx_type'(tlba_pkg::ENTRIES - 1));
   assign shift_en  = (state_ff == ST_SCAN);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE, ST_RESP: begin
            state_in = accept ? ST_SCAN : ST_IDLE;
            step_in  = '0;
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = (func_ff == tlba_pkg::FUNC_INSERT) ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         vpage_ff <= req_vpage;
         wr_ff    <= req_write_access;
         frame_ff <= req_frame_in;
         ro_ff    <= req_readonly_in;
      end
   end

   // scan unit control
   always_comb begin
      scan_ctrl.active       = shift_en;
      scan_ctrl.first        = (step_ff == '0);
      scan_ctrl.func         = func_ff;
      scan_ctrl.vpage        = vpage_ff;
      scan_ctrl.write_access = wr_ff;
      scan_ctrl.step         = step_ff;
   end

   tlba_scan u_scan (
      .clock          (clock),
      .ctrl           (scan_ctrl),
      .head           (cell_q[0]),
      .tail           (tail),
      .hit            (rsp_hit),
      .frame_out      (rsp_frame_out),
      .readonly_write (rsp_readonly_write),
      .victim         (victim),
      .victim_age     (victim_age)
   );

   // entry written by an insert, aged once with its top bit set
   always_comb begin
      new_entry.valid    = 1'b1;
      new_entry.tag      = vpage_ff;
      new_entry.frame    = frame_ff;
      new_entry.readonly = ro_ff;
      new_entry.age      = {1'b1, victim_age[tlba_pkg::AGE_BITS-1:1]};
   end

   // ring of cells; the scanned head re-enters at the tail
   for (genvar i = 0; i < tlba_pkg::ENTRIES; i++) begin : g_cell
      assign load_en[i] = (state_ff == ST_WRITE) && (victim == tlba_pkg::idx_type'(i));
      tlba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .shift_data ((i == tlba_pkg::ENTRIES - 1) ? tail : cell_q[(i + 1) % tlba_pkg::ENTRIES]),
         .load_en    (load_en[i]),
         .load_data  (new_entry),
         .entry      (cell_q[i])
      );
   end

   assign rsp_valid = (state_ff == ST_RESP);

`ifndef ASSERT_OFF
   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not make the block busy");

   // one response per item: the strobe is never held high
   a_single_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // a miss carries no frame and no copy-on-write flag
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_frame_out == '0) && !rsp_readonly_write)
      else $error("miss response carries frame or flag");

   // an insert writes exactly one cell and only then
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> $onehot(load_en))
      else $error("insert write does not hit exactly one cell");
`endif

endmodule

>>> hdl/tlba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_cell: one storage cell of the entry ring
// holds one entry; takes its neighbour's entry when the ring shifts and a new
// entry when the insert write picks this place
// ----------------------------------------------------------------------------
module tlba_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  tlba_pkg::entry_type  shift_data,
   input  logic                 load_en,
   input  tlba_pkg::entry_type  load_data,
   output tlba_pkg::entry_type  entry
);

   tlba_pkg::entry_type entry_ff;
   tlba_pkg::entry_type entry_in;

   // next entry: hold, take from neighbour or load
   always_comb begin
      entry_in = entry_ff;
      if (shift_en) begin
         entry_in = shift_data;
      end else if (load_en) begin
         entry_in = load_data;
      end
   end

   // valid and age start cleared, the rest is payload
   always_ff @(posedge clock) begin
      entry_ff.tag      <= entry_in.tag;
      entry_ff.frame    <= entry_in.frame;
      entry_ff.readonly <= entry_in.readonly;
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.age   <= '0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         entry_ff.age   <= entry_in.age;
      end
   end

   assign entry = entry_ff;

endmodule

>>> hdl/tlba_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_scan: scan unit at the head of the entry ring
// looks at one entry per cycle: tag match and ageing for lookups, running
// minimum of the ages for inserts; keeps the result of the pass
// ----------------------------------------------------------------------------
module tlba_scan (
   input  logic                      clock,
   input  tlba_pkg::scan_ctrl_type   ctrl,
   input  tlba_pkg::entry_type       head,
   output tlba_pkg::entry_type       tail,
   output logic                      hit,
   output tlba_pkg::frame_type       frame_out,
   output logic                      readonly_write,
   output tlba_pkg::idx_type         victim,
   output tlba_pkg::age_type         victim_age
);

   logic                hit_ff, hit_in;
   tlba_pkg::frame_type frame_ff, frame_in;
   logic                rw_ff, rw_in;
   tlba_pkg::idx_type   victim_ff, victim_in;
   tlba_pkg::age_type   min_ff, min_in;
   logic                lookup;
   logic                match;

   assign lookup = (ctrl.func == tlba_pkg::FUNC_LOOKUP);
   assign match  = lookup && head.valid && (head.tag == ctrl.vpage);

   // entry going back into the ring: a lookup ages it, an insert leaves it
   always_comb begin
      tail = head;
      if (lookup) begin
         tail.age = {match, head.age[tlba_pkg::AGE_BITS-1:1]};
      end
   end

   // accumulate over the pass; entries arrive in index order
   always_comb begin
      hit_in    = ctrl.first ? 1'b0 : hit_ff;
      frame_in  = ctrl.first ? '0 : frame_ff;
      rw_in     = ctrl.first ? 1'b0 : rw_ff;
      victim_in = victim_ff;
      min_in    = min_ff;
      if (match) begin
         hit_in   = 1'b1;
         frame_in = head.frame;
         if (ctrl.write_access && head.readonly) begin
            rw_in = 1'b1;
         end
      end
      // lowest index wins a tie, so only a strictly smaller age replaces
      if (ctrl.first || (head.age < min_ff)) begin
         victim_in = ctrl.step;
         min_in    = head.age;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.active) begin
         hit_ff    <= hit_in;
         frame_ff  <= frame_in;
         rw_ff     <= rw_in;
         victim_ff <= victim_in;
         min_ff    <= min_in;
      end
   end

   assign hit            = hit_ff;
   assign frame_out      = frame_ff;
   assign readonly_write = rw_ff;
   assign victim         = victim_ff;
   assign victim_age     = min_ff;

endmodule

>>> dv/tb_tlb_aging_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_aging_lru: self-checking testbench for the aging tlb
// a queue of request items drives lookups and inserts through the start/busy
// handshake with random gaps; an in-bench model of the entries, tags, frames
// and ages predicts every response, which the monitor checks field by field
// ----------------------------------------------------------------------------
module tb_tlb_aging_lru;

   localparam int     CYCLE_LIMIT = 200000;
   localparam int     TAIL_CYCLES = 40;
   localparam int     N_RANDOM    = 450;
   localparam int     POOL_SIZE   = 24;
   localparam tlba_pkg::age_type AGE_TOP = {1'b1, {(tlba_pkg::AGE_BITS-1){1'b0}}};

   // one request item plus its pacing
   typedef struct {
      logic                func;
      tlba_pkg::page_type  vpage;
      logic                write_access;
      tlba_pkg::frame_type frame_in;
      logic                readonly_in;
      int                  gap;
      bit                  drain;
   } tlb_req_type;

   // one response item
   typedef struct {
      logic                hit;
      tlba_pkg::frame_type frame;
      logic                ro_write;
   } tlb_rsp_type;

   logic      clock              = 1'b0;
   logic      reset              = 1'b1;
   logic      start              = 1'b0;
   logic      req_func           = tlba_pkg::FUNC_LOOKUP;
   tlba_pkg::page_type  req_vpage     = '0;
   logic      req_write_access   = 1'b0;
   tlba_pkg::frame_type req_frame_in  = '0;
   logic      req_readonly_in    = 1'b0;
   logic      busy;
   logic      rsp_valid;
   logic      rsp_hit;
   tlba_pkg::frame_type rsp_frame_out;
   logic      rsp_readonly_write;

   tlb_req_type pending_req[$];
   tlb_rsp_type expected_rsp[$];
   int        n_sent     = 0;
   int        n_taken    = 0;
   int        n_mismatch = 0;
   int        n_cycles   = 0;
   int        gap_left   = 0;
   int        burst_left = 0;

   // model copy of the tlb contents
   tlba_pkg::page_type  tag_m   [tlba_pkg::ENTRIES];
   tlba_pkg::frame_type frame_m [tlba_pkg::ENTRIES];
   logic                valid_m [tlba_pkg::ENTRIES];
   logic                ro_m    [tlba_pkg::ENTRIES];
   tlba_pkg::age_type   age_m   [tlba_pkg::ENTRIES];

   tlb_aging_lru uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_vpage          (req_vpage),
      .req_write_access   (req_write_access),
      .req_frame_in       (req_frame_in),
      .req_readonly_in    (req_readonly_in),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_frame_out      (rsp_frame_out),
      .rsp_readonly_write (rsp_readonly_write)
   );

   // clock
   always #4 clock = ~clock;

   // translate or insert one item against the model, ageing as the block does
   function automatic tlb_rsp_type tlb_predict(input tlb_req_type rq);
      tlb_rsp_type r;
      int          victim;
      logic        match;
      r.hit      = 1'b0;
      r.frame    = '0;
      r.ro_write = 1'b0;
      if (rq.func == tlba_pkg::FUNC_LOOKUP) begin
         for (int i = 0; i < tlba_pkg::ENTRIES; i++) begin
            match = valid_m[i] && (tag_m[i] == rq.vpage);
            if (match) begin
               r.hit   = 1'b1;
               r.frame = frame_m[i];
               if (rq.write_access && ro_m[i])
                  r.ro_write = 1'b1;
            end
            age_m[i] = (age_m[i] >> 1) | (match ? AGE_TOP : '0);
         end
      end else begin
         // lowest age wins, lowest index on a tie, validity ignored
         victim = 0;
         for (int i = 1; i < tlba_pkg::ENTRIES; i++)
            if (age_m[i] < age_m[victim])
               victim = i;
         tag_m[victim]   = rq.vpage;
         frame_m[victim] = rq.frame_in;
         ro_m[victim]    = rq.readonly_in;
         valid_m[victim] = 1'b1;
         age_m[victim]   = (age_m[victim] >> 1) | AGE_TOP;
      end
      return r;
   endfunction

   // append an item with a random gap; bursts of back-to-back items now and then
   task automatic add_req(input logic f, input tlba_pkg::page_type pg, input logic wr,
                          input tlba_pkg::frame_type fr, input logic ro, input bit drain);
      tlb_req_type rq;
      rq.func         = f;
      rq.vpage        = pg;
      rq.write_access = wr;
      rq.frame_in     = fr;
      rq.readonly_in  = ro;
      rq.drain        = drain;
      if (burst_left > 0) begin
         rq.gap = 0;
         burst_left--;
      end else begin
         rq.gap = $urandom_range(0, 14);
         if ($urandom_range(0, 29) == 0)
            burst_left = $urandom_range(15, 40);
      end
      pending_req.push_back(rq);
   endtask

   // request driver, changes inputs on the falling edge
   always @(negedge clock) begin : req_driver
      tlb_req_type rq;
      if (reset) begin
         start <= 1'b0;
      end else if (start && n_taken != n_sent) begin
         // item still waiting for the block to take it
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left = gap_left - 1;
      end else if (pending_req.size() != 0 && pending_req[0].drain &&
                   expected_rsp.size() != 0) begin
         // hold off until every outstanding response has come back
         start <= 1'b0;
      end else if (pending_req.size() != 0) begin
         rq = pending_req.pop_front();
         req_func         <= rq.func;
         req_vpage        <= rq.vpage;
         req_write_access <= rq.write_access;
         req_frame_in     <= rq.frame_in;
         req_readonly_in  <= rq.readonly_in;
         start            <= 1'b1;
         n_sent++;
         gap_left = rq.gap;
      end else begin
         start <= 1'b0;
      end
   end

   // response checker and accept tracking on the rising edge
   always @(posedge clock) begin : rsp_monitor
      tlb_rsp_type exp_r;
      tlb_req_type rq;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected response: hit=%0b frame=%02h ro_write=%0b",
                           rsp_hit, rsp_frame_out, rsp_readonly_write);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_hit !== exp_r.hit || rsp_frame_out !== exp_r.frame ||
                   rsp_readonly_write !== exp_r.ro_write) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch: expected hit/frame/ro_write %0b/%02h/%0b, got %0b/%02h/%0b",
                              exp_r.hit, exp_r.frame, exp_r.ro_write,
                              rsp_hit, rsp_frame_out, rsp_readonly_write);
               end
            end
         end
         if (start && !busy) begin
            rq.func         = req_func;
            rq.vpage        = req_vpage;
            rq.write_access = req_write_access;
            rq.frame_in     = req_frame_in;
            rq.readonly_in  = req_readonly_in;
            rq.gap          = 0;
            rq.drain        = 1'b0;
            expected_rsp.push_back(tlb_predict(rq));
            n_taken++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin
      tlba_pkg::page_type pool[POOL_SIZE];
      tlba_pkg::page_type pg;
      logic               f;

      for (int i = 0; i < tlba_pkg::ENTRIES; i++) begin
         tag_m[i]   = '0;
         frame_m[i] = '0;
         valid_m[i] = 1'b0;
         ro_m[i]    = 1'b0;
         age_m[i]   = '0;
      end

      // directed: empty lookups, extremes, read-only writes, duplicates
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'hFFFF, 1'b1, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h0000, 1'b1, 8'hFF, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'h1234, 1'b0, 8'h11, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'h1234, 1'b0, 8'h22, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h1234, 1'b1, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h1234, 1'b0, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'hA5A5, 1'b1, 8'h5A, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'h5A5A, 1'b0, 8'hA5, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'hA5A5, 1'b1, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h5A5A, 1'b1, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h8000, 1'b1, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h0001, 1'b0, 8'h00, 1'b0, 1'b0);
      add_req(tlba_pkg::FUNC_INSERT, 16'h1234, 1'b0, 8'h33, 1'b1, 1'b0);
      add_req(tlba_pkg::FUNC_LOOKUP, 16'h1234, 1'b1, 8'h00, 1'b0, 1'b0);

      // random: mostly a small page pool so that lookups hit and entries churn
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         pool[i] = tlba_pkg::page_type'($urandom);
      for (int i = 0; i < N_RANDOM; i++) begin
         f  = ($urandom_range(0, 99) < 45) ? tlba_pkg::FUNC_INSERT : tlba_pkg::FUNC_LOOKUP;
         pg = ($urandom_range(0, 7) == 0) ? tlba_pkg::page_type'($urandom)
                                          : pool[$urandom_range(0, POOL_SIZE-1)];
         add_req(f, pg, logic'($urandom_range(0, 1)), tlba_pkg::frame_type'($urandom),
                 logic'($urandom_range(0, 1)), (i == 0) || ($urandom_range(0, 39) == 0));
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || n_taken != n_sent)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (n_mismatch == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> tlb_aging_lru.f
hdl/tlba_pkg.sv
hdl/tlba_cell.sv
hdl/tlba_scan.sv
hdl/tlb_aging_lru.sv
dv/tb_tlb_aging_lru.sv
